// ----- src/e2q_pkg.sv -----
// e2q_pkg: shared constants and functions for the euler_to_quaternion_unit
// holds the cordic arctangent table and its gain; no dependencies
package e2q_pkg;

   localparam int CORDIC_STEPS = 32;
   localparam int CORDIC_W = 64;
   localparam logic [CORDIC_W-1:0] CORDIC_GAIN = 64'd652032874;

   function automatic logic [31:0] atan_turns(input logic [4:0] idx);
      logic [31:0] v;
      case (idx)
         5'd0: v = 32'd536870912;
         5'd1: v = 32'd316933406;
         5'd2: v = 32'd167458907;
         5'd3: v = 32'd85004756;
         5'd4: v = 32'd42667331;
         5'd5: v = 32'd21354465;
         5'd6: v = 32'd10679838;
         5'd7: v = 32'd5340245;
         5'd8: v = 32'd2670163;
         5'd9: v = 32'd1335087;
         5'd10: v = 32'd667544;
         5'd11: v = 32'd333772;
         5'd12: v = 32'd166886;
         5'd13: v = 32'd83443;
         5'd14: v = 32'd41722;
         5'd15: v = 32'd20861;
         5'd16: v = 32'd10430;
         5'd17: v = 32'd5215;
         5'd18: v = 32'd2608;
         5'd19: v = 32'd1304;
         5'd20: v = 32'd652;
         5'd21: v = 32'd326;
         5'd22: v = 32'd163;
         5'd23: v = 32'd81;
         5'd24: v = 32'd41;
         5'd25: v = 32'd20;
         5'd26: v = 32'd10;
         5'd27: v = 32'd5;
         5'd28: v = 32'd3;
         5'd29: v = 32'd1;
         5'd30: v = 32'd1;
         default: v = 32'd0;
      endcase
      return v;
   endfunction

endpackage

// ----- src/euler_to_quaternion_unit.sv -----
// euler_to_quaternion_unit: zyx euler angles to fixed point quaternion
// depends on e2q_pkg, e2q_cordic and e2q_combine
//
// usage:
//   req_ channel carries one request per roll, pitch, yaw triple as binary
//   angles (2^(ANGLE_BITS-1) is pi). rsp_ channel returns x, y, z, w in
//   signed fixed point with COMPONENT_BITS-2 fraction bits, saturated at +-1.
//   the pipe has 32 cordic stages, then product, triple product, sum and
//   round/saturate stages, each one register. throughput is one request
//   per cycle while the output is not stalled; the pipe advances together.
//   the pipe freezes, and req_tready drops, only when rsp_tready is low
//   while the output holds a result, so nothing is lost or repeated.
//   reset (synchronous, active high) clears all valid bits; data registers
//   are not reset.
module euler_to_quaternion_unit #(
   parameter int ANGLE_BITS = 16,
   parameter int COMPONENT_BITS = 16
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // roll_angle, pitch_angle, yaw_angle from lowest bit
   input  logic [((3*ANGLE_BITS+7)/8)*8-1:0] req_tdata,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // quat_x, quat_y, quat_z, quat_w from lowest bit
   output logic [((4*COMPONENT_BITS+7)/8)*8-1:0] rsp_tdata
);
   localparam int DEPTH = e2q_pkg::CORDIC_STEPS + 4;
   localparam int OW = ((4*COMPONENT_BITS+7)/8)*8;

   logic [DEPTH-1:0] valid_ff, valid_in;
   logic enable;
   logic signed [63:0] cr, sr, cp, sp, cy, sy;
   logic [4*COMPONENT_BITS-1:0] quat;

   assign enable = rsp_tready || !valid_ff[DEPTH-1];
   assign req_tready = enable;
   assign valid_in = {valid_ff[DEPTH-2:0], req_tvalid};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (enable) begin
         valid_ff <= valid_in;
      end
   end

   e2q_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_roll (.clock, .enable,
      .angle(req_tdata[0 +: ANGLE_BITS]), .cos_out(cr), .sin_out(sr));
   e2q_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_pitch (.clock, .enable,
      .angle(req_tdata[ANGLE_BITS +: ANGLE_BITS]), .cos_out(cp), .sin_out(sp));
   e2q_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_yaw (.clock, .enable,
      .angle(req_tdata[2*ANGLE_BITS +: ANGLE_BITS]), .cos_out(cy), .sin_out(sy));

   e2q_combine #(.COMPONENT_BITS(COMPONENT_BITS)) u_combine (.clock, .enable,
      .cr, .sr, .cp, .sp, .cy, .sy, .quat);

   assign rsp_tvalid = valid_ff[DEPTH-1];
   assign rsp_tdata = OW'(quat);

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed under stall");
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid && !rsp_tready)
      else $error("ready dropped without stall");
   a_flow: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> valid_ff[0])
      else $error("accepted request lost");
endmodule

// ----- src/e2q_cordic.sv -----
// e2q_cordic: pipelined rotation cordic giving cos and sin of a half angle
// one register stage per iteration; uses e2q_pkg
module e2q_cordic #(
   parameter int ANGLE_BITS = 16
) (
   input  logic                 clock,
   input  logic                 enable,
   input  logic [ANGLE_BITS-1:0] angle,
   output logic signed [63:0]   cos_out,
   output logic signed [63:0]   sin_out
);
   localparam int N = e2q_pkg::CORDIC_STEPS;

   logic signed [63:0] x_ff [N];
   logic signed [63:0] y_ff [N];
   logic signed [63:0] z_ff [N];
   logic signed [63:0] x_in [N];
   logic signed [63:0] y_in [N];
   logic signed [63:0] z_in [N];
   logic signed [63:0] phase;

   assign phase = 64'(signed'(angle)) <<< (39 - ANGLE_BITS);

   always_comb begin
      for (int i = 0; i < N; i++) begin
         logic signed [63:0] xp, yp, zp, da;
         xp = (i == 0) ? signed'(e2q_pkg::CORDIC_GAIN) : x_ff[(i == 0) ? 0 : i-1];
         yp = (i == 0) ? 64'sd0 : y_ff[(i == 0) ? 0 : i-1];
         zp = (i == 0) ? phase : z_ff[(i == 0) ? 0 : i-1];
         da = signed'({24'd0, e2q_pkg::atan_turns(5'(i)), 8'd0});
         if (!zp[63]) begin
            x_in[i] = xp - (yp >>> i);
            y_in[i] = yp + (xp >>> i);
            z_in[i] = zp - da;
         end else begin
            x_in[i] = xp + (yp >>> i);
            y_in[i] = yp - (xp >>> i);
            z_in[i] = zp + da;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         for (int i = 0; i < N; i++) begin
            x_ff[i] <= x_in[i];
            y_ff[i] <= y_in[i];
            z_ff[i] <= z_in[i];
         end
      end
   end

   assign cos_out = x_ff[N-1];
   assign sin_out = y_ff[N-1];
endmodule

// ----- src/e2q_combine.sv -----
// e2q_combine: triple products, sums, rounding and saturation
// four register stages; no package dependency
module e2q_combine #(
   parameter int COMPONENT_BITS = 16
) (
   input  logic                       clock,
   input  logic                       enable,
   input  logic signed [63:0]         cr, sr, cp, sp, cy, sy,
   output logic [4*COMPONENT_BITS-1:0] quat
);
   localparam int SH = 60 - (COMPONENT_BITS - 2);
   localparam logic signed [63:0] LIM = 64'sd1 <<< (COMPONENT_BITS - 2);

   // stage 1: pair products a*b >> 30 (q30 values fit in 32 bits)
   logic signed [31:0] cp_ff, sp_ff;
   // cy*sr, sy*cr, cy*cr, sy*sr
   logic signed [31:0] p_cysr_ff, p_sycr_ff, p_cycr_ff, p_sysr_ff;
   // stage 2: triple products
   logic signed [63:0] t_ff [8];
   // stage 3: sums
   logic signed [63:0] s_ff [4];
   logic [4*COMPONENT_BITS-1:0] q_in;

   function automatic logic signed [63:0] mul32(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
      return 64'(a) * 64'(b);
   endfunction

   always_ff @(posedge clock) begin
      if (enable) begin
         p_cysr_ff <= 32'(mul32(cy[31:0], sr[31:0]) >>> 30);
         p_sycr_ff <= 32'(mul32(sy[31:0], cr[31:0]) >>> 30);
         p_cycr_ff <= 32'(mul32(cy[31:0], cr[31:0]) >>> 30);
         p_sysr_ff <= 32'(mul32(sy[31:0], sr[31:0]) >>> 30);
         cp_ff <= cp[31:0];
         sp_ff <= sp[31:0];
         t_ff[0] <= mul32(p_cysr_ff, cp_ff);
         t_ff[1] <= mul32(p_sycr_ff, sp_ff);
         t_ff[2] <= mul32(p_cycr_ff, sp_ff);
         t_ff[3] <= mul32(p_sysr_ff, cp_ff);
         t_ff[4] <= mul32(p_sycr_ff, cp_ff);
         t_ff[5] <= mul32(p_cysr_ff, sp_ff);
         t_ff[6] <= mul32(p_cycr_ff, cp_ff);
         t_ff[7] <= mul32(p_sysr_ff, sp_ff);
         s_ff[0] <= t_ff[0] - t_ff[1];
         s_ff[1] <= t_ff[2] + t_ff[3];
         s_ff[2] <= t_ff[4] - t_ff[5];
         s_ff[3] <= t_ff[6] + t_ff[7];
         quat <= q_in;
      end
   end

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         logic signed [63:0] r;
         r = (s_ff[k] + (64'sd1 <<< (SH - 1))) >>> SH;
         if (r > LIM) r = LIM;
         if (r < -LIM) r = -LIM;
         q_in[k*COMPONENT_BITS +: COMPONENT_BITS] = r[COMPONENT_BITS-1:0];
      end
   end
endmodule

// ----- dv/testbench.sv -----
// testbench for euler_to_quaternion_unit: random and directed angle requests
// checked against a cordic-based quaternion predictor; depends on e2q_pkg
`timescale 1ns / 1ps

module testbench;

   localparam int AB = 16;
   localparam int CB = 16;
   localparam int LATENCY = 36;

   typedef struct packed {
      logic signed [15:0] yaw;
      logic signed [15:0] pitch;
      logic signed [15:0] roll;
   } angles_type;

   typedef struct packed {
      logic signed [15:0] w;
      logic signed [15:0] z;
      logic signed [15:0] y;
      logic signed [15:0] x;
   } quat_type;

   logic clock = 0;
   logic reset = 1;
   logic req_tvalid = 0;
   logic req_tready;
   logic [47:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 0;
   logic [63:0] rsp_tdata;

   euler_to_quaternion_unit i_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   always begin
      #6 clock = 1;
      #6 clock = 0;
   end

   angles_type pending_angles[$];
   quat_type expected_quats[$];
   int errors = 0;
   bit stimulus_done = 0;
   bit drain_request = 0;
   int hold_cycles = 0;

   function automatic void half_sin_cos(input logic signed [15:0] ang,
                                        output longint c, output longint s);
      longint x, y, z, dx, dy, da;
      x = 652032874;
      y = 0;
      z = longint'(ang) * (longint'(1) << (39 - AB));
      for (int i = 0; i < 32; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         da = longint'(e2q_pkg::atan_turns(i[4:0])) * 256;
         if (z >= 0) begin
            x -= dx; y += dy; z -= da;
         end else begin
            x += dx; y -= dy; z += da;
         end
      end
      c = x;
      s = y;
   endfunction

   function automatic longint triple(longint a, longint b, longint c);
      longint p;
      p = a * b;
      return (p >>> 30) * c;
   endfunction

   function automatic logic [15:0] round_sat(longint q60);
      longint r, lim;
      lim = longint'(1) << (CB - 2);
      r = (q60 + (longint'(1) << (60 - (CB - 2) - 1))) >>> (60 - (CB - 2));
      if (r > lim) r = lim;
      if (r < -lim) r = -lim;
      return r[15:0];
   endfunction

   function automatic quat_type euler_to_quat(angles_type a);
      longint cr, sr, cp, sp, cy, sy;
      quat_type q;
      half_sin_cos(a.roll, cr, sr);
      half_sin_cos(a.pitch, cp, sp);
      half_sin_cos(a.yaw, cy, sy);
      q.x = round_sat(triple(cy, sr, cp) - triple(sy, cr, sp));
      q.y = round_sat(triple(cy, cr, sp) + triple(sy, sr, cp));
      q.z = round_sat(triple(sy, cr, cp) - triple(cy, sr, sp));
      q.w = round_sat(triple(cy, cr, cp) + triple(sy, sr, sp));
      return q;
   endfunction

   // driver
   int send_gap = 0;
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            expected_quats.push_back(euler_to_quat(angles_type'(req_tdata)));
            pending_angles.pop_front();
            send_gap = $urandom_range(0, 15);
            if ($urandom_range(0, 3) == 0) send_gap = 0;
         end
         if (send_gap > 0) begin
            send_gap--;
            req_tvalid <= 0;
         end else if (drain_request && pending_angles.size() > 0 &&
                      expected_quats.size() > 0 && !(req_tvalid && !req_tready)) begin
            req_tvalid <= 0;
         end else if (pending_angles.size() > 0) begin
            if (drain_request && expected_quats.size() == 0) drain_request = 0;
            req_tvalid <= 1;
            req_tdata <= pending_angles[0];
         end else begin
            req_tvalid <= 0;
            if (!req_tvalid) stimulus_done = 1;
         end
      end
   end

   // monitor
   int recv_gap = 0;
   always @(posedge clock) begin
      quat_type got, exp_q;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got = quat_type'(rsp_tdata);
            if (expected_quats.size() == 0) begin
               $error("unexpected response %h", rsp_tdata);
               errors++;
            end else begin
               exp_q = expected_quats.pop_front();
               if (got.x !== exp_q.x) begin
                  $error("quat_x exp %0d got %0d", exp_q.x, got.x); errors++;
               end
               if (got.y !== exp_q.y) begin
                  $error("quat_y exp %0d got %0d", exp_q.y, got.y); errors++;
               end
               if (got.z !== exp_q.z) begin
                  $error("quat_z exp %0d got %0d", exp_q.z, got.z); errors++;
               end
               if (got.w !== exp_q.w) begin
                  $error("quat_w exp %0d got %0d", exp_q.w, got.w); errors++;
               end
            end
            recv_gap = $urandom_range(0, 15);
            if ($urandom_range(0, 3) == 0) recv_gap = 0;
         end
         if (hold_cycles > 0) begin
            hold_cycles--;
            rsp_tready <= 0;
         end else if (recv_gap > 0) begin
            recv_gap--;
            rsp_tready <= 0;
         end else begin
            rsp_tready <= 1;
         end
      end
   end

   function automatic logic [15:0] rand_angle();
      case ($urandom_range(0, 5))
         0: return 16'h8000;
         1: return 16'h7fff;
         2: return 16'($urandom_range(0, 1) ? 16'h4000 : 16'hc000);
         3: return 16'($urandom_range(0, 64) - 32);
         default: return 16'($urandom);
      endcase
   endfunction

   initial begin
      angles_type a;
      logic [15:0] corner[8];
      corner = '{16'h0000, 16'h7fff, 16'h8000, 16'h4000,
                 16'hc000, 16'h0001, 16'hffff, 16'h2000};
      for (int i = 0; i < 8; i++) begin
         a.roll = corner[i]; a.pitch = corner[(i + 3) % 8]; a.yaw = corner[(i + 5) % 8];
         pending_angles.push_back(a);
      end
      for (int i = 0; i < 8; i++) begin
         a = '0;
         if (i < 3) a.roll = corner[i + 1];
         else if (i < 6) a.pitch = corner[i - 2];
         else a.yaw = corner[i - 5];
         pending_angles.push_back(a);
      end
      // same angle on all axes drives components toward saturation
      for (int i = 1; i < 8; i++) begin
         a.roll = corner[i]; a.pitch = corner[i]; a.yaw = corner[i];
         pending_angles.push_back(a);
      end
      for (int i = 0; i < 1250; i++) begin
         a.roll = rand_angle(); a.pitch = rand_angle(); a.yaw = rand_angle();
         pending_angles.push_back(a);
      end
      repeat (7) @(posedge clock);
      reset <= 0;
      repeat (200) @(posedge clock);
      // long receiver hold so the pipe fills and the input stalls
      hold_cycles = 400;
      repeat (600) @(posedge clock);
      drain_request = 1;
      wait (stimulus_done);
      wait (expected_quats.size() == 0);
      repeat (LATENCY + 10) @(posedge clock);
      if (errors == 0 && expected_quats.size() == 0) begin
         $display("testbench: clean");
      end else begin
         $display("testbench: errors");
      end
      $finish;
   end

   initial begin
      #5ms;
      $display("testbench: errors");
      $finish;
   end

endmodule
